// ----- rtl/core/fvud_pkg.sv -----
// shared types, character constants and helpers for the form value url decoder
`default_nettype none

package fvud_pkg;

    // default value buffer size, the value is capped one byte short of it
    localparam int MESSAGE_BYTES = 1024;

    // result queue between the decode stage and the output port
    localparam int RBUF_DEPTH = 4;
    localparam int RBUF_AW    = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_M     = 8'h6D;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_NO_HDR = 2'd1,
        ST_NO_MSG = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       message_end;
        logic [1:0] status;
    } t_out_item;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        t_out_item  r0;
        t_out_item  r1;
    } t_push;

    // blank line that ends the header: cr lf cr lf
    function automatic logic [7:0] hdr_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = CH_CR;
            2'd1:    c = CH_LF;
            2'd2:    c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

    // parameter key "message="
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h6D;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h73;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h61;
            3'd5:    c = 8'h67;
            3'd6:    c = 8'h65;
            default: c = 8'h3D;
        endcase
        return c;
    endfunction

    // bit 4 set for a valid hex digit, low nibble is its value
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        priority if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)     r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)     r = {1'b1, 4'(c - 8'h37)};
        else                                   r = 5'd0;
        return r;
    endfunction

    // bytes that end the value
    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_AMP) || (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fvud_step.sv -----
// decode stage: header and key search, value decoding, state registers
`default_nettype none

module fvud_step #(
    parameter int MESSAGE_BYTES = fvud_pkg::MESSAGE_BYTES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire fvud_pkg::t_in_item i_item,
    output fvud_pkg::t_push         o_push
);

    localparam int BW = $clog2(MESSAGE_BYTES);
    localparam logic [BW:0] CAP_W = (BW + 1)'(MESSAGE_BYTES - 1);

    localparam logic [1:0] HP_NONE = 2'd0;
    localparam logic [1:0] HP_ONE  = 2'd1;
    localparam logic [1:0] HP_TWO  = 2'd2;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_BODY   = 6'b000010,
        PH_VALUE  = 6'b000100,
        PH_DONE   = 6'b001000,
        PH_NOHDR  = 6'b010000,
        PH_NOMSG  = 6'b100000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_mp, n_mp;
    logic [1:0]  r_hp, n_hp;
    logic [7:0]  r_fhc, n_fhc;
    logic [BW-1:0] r_bw, n_bw;

    logic [7:0]  b;
    logic        last;
    logic [1:0]  k;
    logic [7:0]  p0, p1;
    logic        cl;
    logic        seq;
    logic [7:0]  c_sel;
    logic [4:0]  hv_hi, hv_lo;
    logic [7:0]  dec;
    logic [BW:0] bw1, bw2;
    logic        cap0, cap1;
    logic        closed;
    fvud_pkg::t_push push;

    assign b     = i_item.data_byte;
    assign last  = i_item.last_byte;
    assign hv_hi = fvud_pkg::hex_val(r_fhc);
    assign hv_lo = fvud_pkg::hex_val(b);
    assign dec   = (hv_hi[4] && hv_lo[4]) ? {hv_hi[3:0], hv_lo[3:0]} : 8'd0;
    assign bw1   = {1'b0, r_bw} + (BW + 1)'(1);
    assign bw2   = {1'b0, r_bw} + (BW + 1)'(2);
    assign cap0  = bw1 >= CAP_W;
    assign cap1  = bw2 >= CAP_W;

    always_comb begin
        n_phase = r_phase;
        n_mp    = r_mp;
        n_hp    = r_hp;
        n_fhc   = r_fhc;
        n_bw    = r_bw;
        k       = 2'd0;
        p0      = fvud_pkg::CH_NUL;
        p1      = fvud_pkg::CH_NUL;
        cl      = 1'b0;
        seq     = 1'b0;
        c_sel   = b;
        closed  = 1'b0;
        push    = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (b == fvud_pkg::CH_NUL) begin
                    n_phase = PH_NOHDR;
                end else if (b == fvud_pkg::hdr_char(r_mp[1:0])) begin
                    if (r_mp == 3'd3) begin
                        n_phase = PH_BODY;
                        n_mp    = 3'd0;
                    end else begin
                        n_mp = r_mp + 3'd1;
                    end
                end else begin
                    n_mp = (b == fvud_pkg::CH_CR) ? 3'd1 : 3'd0;
                end
            end
            PH_BODY: begin
                if (b == fvud_pkg::CH_NUL) begin
                    n_phase = PH_NOMSG;
                end else if (b == fvud_pkg::key_char(r_mp)) begin
                    if (r_mp == 3'd7) begin
                        n_phase = PH_VALUE;
                        n_mp    = 3'd0;
                        cl      = last;     // value starts on the last byte: empty
                    end else begin
                        n_mp = r_mp + 3'd1;
                    end
                end else begin
                    n_mp = (b == fvud_pkg::CH_M) ? 3'd1 : 3'd0;
                end
            end
            PH_VALUE: begin
                unique case (r_hp)
                    HP_NONE: begin
                        if (fvud_pkg::is_term(b)) begin
                            cl = 1'b1;
                        end else if (b == fvud_pkg::CH_PLUS) begin
                            k  = 2'd1;
                            p0 = fvud_pkg::CH_SPACE;
                            cl = last;
                        end else if (b == fvud_pkg::CH_PCT) begin
                            if (last) begin
                                k  = 2'd1;
                                p0 = fvud_pkg::CH_PCT;
                                cl = 1'b1;
                            end else begin
                                n_hp = HP_ONE;
                            end
                        end else begin
                            k  = 2'd1;
                            p0 = b;
                            cl = last;
                        end
                    end
                    HP_ONE: begin
                        if (b == fvud_pkg::CH_NUL) begin
                            k  = 2'd1;
                            p0 = fvud_pkg::CH_PCT;
                            cl = 1'b1;
                        end else if (last) begin
                            seq   = 1'b1;
                            c_sel = b;
                        end else begin
                            n_hp  = HP_TWO;
                            n_fhc = b;
                        end
                    end
                    HP_TWO: begin
                        if (b == fvud_pkg::CH_NUL) begin
                            seq   = 1'b1;
                            c_sel = r_fhc;
                        end else begin
                            k    = 2'd1;
                            p0   = dec;
                            cl   = last;
                            n_hp = HP_NONE;
                        end
                    end
                    default: begin
                        n_hp = HP_NONE;
                    end
                endcase
            end
            default: begin
            end
        endcase

        // escape cut short: '%' then its one pending byte ('+' as space) unless that byte ends the value
        if (seq) begin
            k  = fvud_pkg::is_term(c_sel) ? 2'd1 : 2'd2;
            p0 = fvud_pkg::CH_PCT;
            p1 = (c_sel == fvud_pkg::CH_PLUS) ? fvud_pkg::CH_SPACE : c_sel;
            cl = 1'b1;
        end

        // length cap drops whatever follows the capping byte
        if (k != 2'd0 && cap0) begin
            push.count = 2'd1;
            push.r0    = '{p0, 1'b1, 1'b1, fvud_pkg::ST_FOUND};
            n_bw       = BW'(bw1);
            closed     = 1'b1;
        end else if (k == 2'd2) begin
            push.count = 2'd2;
            push.r0    = '{p0, 1'b1, 1'b0, fvud_pkg::ST_FOUND};
            push.r1    = '{p1, 1'b1, 1'b1, fvud_pkg::ST_FOUND};
            n_bw       = BW'(bw2);
            closed     = 1'b1;
        end else if (k == 2'd1) begin
            push.count = 2'd1;
            push.r0    = '{p0, 1'b1, cl, fvud_pkg::ST_FOUND};
            n_bw       = BW'(bw1);
            closed     = cl;
        end else if (cl) begin
            push.count = 2'd1;
            push.r0    = '{fvud_pkg::CH_NUL, 1'b0, 1'b1, fvud_pkg::ST_FOUND};
            closed     = 1'b1;
        end

        if (closed) begin
            n_phase = PH_DONE;
            n_hp    = HP_NONE;
        end

        if (last) begin
            if (n_phase == PH_HEADER || n_phase == PH_NOHDR) begin
                push.count = 2'd1;
                push.r0    = '{fvud_pkg::CH_NUL, 1'b0, 1'b1, fvud_pkg::ST_NO_HDR};
            end else if (n_phase == PH_BODY || n_phase == PH_NOMSG) begin
                push.count = 2'd1;
                push.r0    = '{fvud_pkg::CH_NUL, 1'b0, 1'b1, fvud_pkg::ST_NO_MSG};
            end
            n_phase = PH_HEADER;
            n_mp    = 3'd0;
            n_hp    = HP_NONE;
            n_fhc   = fvud_pkg::CH_NUL;
            n_bw    = '0;
        end

        if (!i_adv) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_mp    <= 3'd0;
            r_hp    <= HP_NONE;
            r_fhc   <= fvud_pkg::CH_NUL;
            r_bw    <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_mp    <= n_mp;
            r_hp    <= n_hp;
            r_fhc   <= n_fhc;
            r_bw    <= n_bw;
        end
    end

`ifndef ASSERT_OFF
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_item.last_byte |=>
            r_phase == PH_HEADER && r_bw == '0 && r_hp == HP_NONE)
        else $error("state not back to header search after last byte");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count == 2'd2 |->
            o_push.r1.message_end && !o_push.r0.message_end && o_push.r0.byte_valid)
        else $error("two results in one item not ordered as byte then closing byte");

    a_fail_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count != 2'd0 && o_push.r0.status != fvud_pkg::ST_FOUND |->
            o_push.count == 2'd1 && !o_push.r0.byte_valid && o_push.r0.message_end)
        else $error("failure status mixed with value bytes");

    a_cap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VALUE |-> {1'b0, r_bw} < CAP_W)
        else $error("value still open past the length cap");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/fvud_rbuf.sv -----
// result queue: takes up to two results a cycle, gives one a cycle while the output is ready
`default_nettype none

module fvud_rbuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fvud_pkg::t_push     i_push,
    output logic                     o_room,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output fvud_pkg::t_out_item      o_out_data
);

    localparam int AW = fvud_pkg::RBUF_AW;

    fvud_pkg::t_out_item r_mem [fvud_pkg::RBUF_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW:0]   r_count, n_count;
    logic          pop;
    logic [AW-1:0] wr_ptr1;

    assign pop      = (r_count != '0) && i_out_ready;
    assign wr_ptr1  = r_wr_ptr + AW'(1);
    assign n_wr_ptr = r_wr_ptr + AW'(i_push.count);
    assign n_rd_ptr = r_rd_ptr + AW'(pop);
    assign n_count  = r_count + (AW + 1)'(i_push.count) - (AW + 1)'(pop);

    // room for two more results without looking at this cycle's pop
    assign o_room      = r_count <= (AW + 1)'(fvud_pkg::RBUF_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd0 |-> o_room)
        else $error("results pushed without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW + 1)'(fvud_pkg::RBUF_DEPTH))
        else $error("result queue overfilled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == (AW + 1)'(1) && pop && i_push.count == 2'd0 |=> !o_out_valid)
        else $error("queue still valid after its only result left");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/form_value_url_decoder_top.sv -----
// top level of the form value url decoder: input register, decode stage, result queue
// an accepted item passes the input register and the decode stage, then the result queue
// throughput: one item per cycle while the queue has room; an item that gives two results puts them out in turn
// the input side stalls only when the 4-entry result queue has fewer than two free entries
// reset: synchronous active-low i_rst_n clears the input valid flag, the queue pointers and
// all search and decode state; no clearing pass, items are taken right after reset
`default_nettype none

module form_value_url_decoder_top #(
    parameter int MESSAGE_BYTES = fvud_pkg::MESSAGE_BYTES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request bytes in
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire fvud_pkg::t_in_item  i_in_data,
    // decoded value bytes and status out
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output fvud_pkg::t_out_item      o_out_data
);

    // input register, one item deep
    logic                r_in_valid, n_in_valid;
    fvud_pkg::t_in_item  r_in_data;

    logic                room;
    logic                adv;
    logic                take;
    fvud_pkg::t_push     push;

    // the registered item moves on whenever the queue can absorb two results
    assign adv        = r_in_valid && room;
    // a new item may land while the old one moves on in the same cycle
    assign o_in_ready = !r_in_valid || room;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (take) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // payload register needs no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_data <= i_in_data;
        end
    end

    // header / key search and percent decoding, one item per cycle while the queue has room
    fvud_step #(
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in_data),
        .o_push  (push)
    );

    // results queue up here so the decode stage keeps going under output stalls
    fvud_rbuf u_rbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_hold_until_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !room |=> r_in_valid && $stable(r_in_data))
        else $error("registered item lost while queue was full");

    a_push_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |-> r_in_valid)
        else $error("result pushed with no item in the input register");

    a_every_item_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !take |=> !r_in_valid)
        else $error("input register kept an item that already moved on");
`endif

endmodule

`default_nettype wire

// ----- test/form_value_url_decoder_tb.sv -----
// self-checking testbench for the form value url decoder: directed requests, then random ones
module tb;

    // the value is capped one byte short of the buffer size
    localparam int CAP_BYTES    = fvud_pkg::MESSAGE_BYTES - 1;
    // request bytes for the whole run, directed and random; random ones fill up to it
    localparam int TOTAL_ITEMS  = 1750;
    // cycles with no handshake on either side before the run is given up
    localparam int STALL_LIMIT  = 5000;
    // settle time after the last result: two stages plus margin
    localparam int DRAIN_CYCLES = 8;
    // parameter key as packed text, first character in the top byte
    localparam logic [63:0] KEY_TEXT = "message=";

    // where the predictor is in the request
    typedef enum logic [2:0] {
        SCAN_HEADER,
        SCAN_BODY,
        IN_VALUE,
        VALUE_DONE,
        NO_HEADER,
        NO_KEY
    } t_scan;

    // escape progress inside the value
    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_OPEN,
        ESC_ONE
    } t_esc;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    fvud_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    fvud_pkg::t_out_item o_out_data;

    form_value_url_decoder_top #(
        .MESSAGE_BYTES(fvud_pkg::MESSAGE_BYTES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // idling controls, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // predictor state
    t_scan       scan;
    int unsigned key_pos;
    t_esc        esc_state;
    logic [7:0]  esc_first;
    int unsigned value_len;

    // results of the byte being predicted, at most two
    fvud_pkg::t_out_item step_out [4];
    int                  step_n;

    // decoded bytes and status reports still to come out of the block
    fvud_pkg::t_out_item expected_results [$];

    // bytes of the random request being built
    logic [7:0]  req_bytes [$];

    // run statistics
    int items_sent      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int values_closed   = 0;
    int values_capped   = 0;
    int no_header_seen  = 0;
    int no_key_seen     = 0;
    int quiet_cycles    = 0;

    fvud_pkg::t_out_item want;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic void clear_decoder();
        scan      = SCAN_HEADER;
        key_pos   = 0;
        esc_state = ESC_NONE;
        esc_first = 8'h00;
        value_len = 0;
    endfunction

    function automatic void emit(input logic [7:0] b, input logic v, input logic e,
                                 input fvud_pkg::t_status s);
        step_out[step_n] = '{out_byte: b, byte_valid: v, message_end: e, status: s};
        step_n++;
    endfunction

    // one decoded byte; the cap closes the value on that same result
    function automatic void emit_value_byte(input logic [7:0] b);
        emit(b, 1'b1, 1'b0, fvud_pkg::ST_FOUND);
        value_len++;
        if (value_len >= CAP_BYTES) begin
            step_out[step_n - 1].message_end = 1'b1;
            scan      = VALUE_DONE;
            esc_state = ESC_NONE;
            values_capped++;
        end
    endfunction

    // end marker rides on the last decoded byte of this step if it can
    function automatic void close_value();
        if (step_n > 0 && !step_out[step_n - 1].message_end)
            step_out[step_n - 1].message_end = 1'b1;
        else
            emit(8'h00, 1'b0, 1'b1, fvud_pkg::ST_FOUND);
        scan      = VALUE_DONE;
        esc_state = ESC_NONE;
        values_closed++;
    endfunction

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    // value byte with no escape open
    function automatic void plain_value_byte(input logic [7:0] b);
        if (scan != IN_VALUE) return;
        if (b == fvud_pkg::CH_NUL || b == fvud_pkg::CH_AMP ||
            b == fvud_pkg::CH_CR || b == fvud_pkg::CH_LF)
            close_value();
        else if (b == fvud_pkg::CH_PLUS)
            emit_value_byte(fvud_pkg::CH_SPACE);
        else if (b == fvud_pkg::CH_PCT)
            esc_state = ESC_OPEN;
        else
            emit_value_byte(b);
    endfunction

    // value byte in any escape state; a zero byte stands for the end of the text
    function automatic void value_byte(input logic [7:0] b);
        logic [7:0] held;
        int         hi;
        int         lo;
        if (scan != IN_VALUE) return;
        case (esc_state)
            ESC_NONE: plain_value_byte(b);
            ESC_OPEN: begin
                if (b == fvud_pkg::CH_NUL) begin
                    esc_state = ESC_NONE;
                    emit_value_byte(fvud_pkg::CH_PCT);
                    if (scan == IN_VALUE) close_value();
                end else begin
                    esc_first = b;
                    esc_state = ESC_ONE;
                end
            end
            default: begin
                if (b == fvud_pkg::CH_NUL) begin
                    // escape cut short after one byte: '%', that byte, then the end
                    held      = esc_first;
                    esc_state = ESC_NONE;
                    emit_value_byte(fvud_pkg::CH_PCT);
                    plain_value_byte(held);
                    if (scan == IN_VALUE) begin
                        if (esc_state == ESC_NONE) begin
                            close_value();
                        end else begin
                            esc_state = ESC_NONE;
                            emit_value_byte(fvud_pkg::CH_PCT);
                            if (scan == IN_VALUE) close_value();
                        end
                    end
                end else begin
                    hi        = digit_value(esc_first);
                    lo        = digit_value(b);
                    esc_state = ESC_NONE;
                    emit_value_byte((hi < 0 || lo < 0) ? 8'h00 : 8'(hi * 16 + lo));
                end
            end
        endcase
    endfunction

    // predict the results of one accepted request byte
    function automatic void decode_request_byte(input logic [7:0] b, input logic last);
        step_n = 0;
        case (scan)
            SCAN_HEADER: begin
                // blank line: cr lf cr lf
                if (b == fvud_pkg::CH_NUL) begin
                    scan = NO_HEADER;
                end else if (b == (key_pos[0] ? fvud_pkg::CH_LF : fvud_pkg::CH_CR)) begin
                    key_pos++;
                    if (key_pos == 4) begin
                        scan    = SCAN_BODY;
                        key_pos = 0;
                    end
                end else begin
                    key_pos = (b == fvud_pkg::CH_CR) ? 1 : 0;
                end
            end
            SCAN_BODY: begin
                if (b == fvud_pkg::CH_NUL) begin
                    scan = NO_KEY;
                end else if (b == KEY_TEXT[63 - 8 * key_pos -: 8]) begin
                    key_pos++;
                    if (key_pos == 8) begin
                        scan    = IN_VALUE;
                        key_pos = 0;
                    end
                end else begin
                    key_pos = (b == fvud_pkg::CH_M) ? 1 : 0;
                end
            end
            IN_VALUE: value_byte(b);
            default: ;
        endcase
        if (last) begin
            if (scan == IN_VALUE) begin
                value_byte(fvud_pkg::CH_NUL);
            end else if (scan == SCAN_HEADER || scan == NO_HEADER) begin
                emit(8'h00, 1'b0, 1'b1, fvud_pkg::ST_NO_HDR);
                no_header_seen++;
            end else if (scan == SCAN_BODY || scan == NO_KEY) begin
                emit(8'h00, 1'b0, 1'b1, fvud_pkg::ST_NO_MSG);
                no_key_seen++;
            end
            clear_decoder();
        end
        for (int k = 0; k < step_n; k++) expected_results.push_back(step_out[k]);
    endfunction

    // ---------------------------------------------------------------
    // result side: random stalls, checking, watchdog
    // ---------------------------------------------------------------

    // ready changes on the falling edge only
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void report_field(input string name, input logic [7:0] expv,
                                         input logic [7:0] actv);
        $display("%0t: %s expected %0h got %0h", $time, name, expv, actv);
        mismatches++;
    endfunction

    // compare each result with the oldest prediction, field by field
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result expected none got %h", $time, o_out_data);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_data.out_byte !== want.out_byte)
                    report_field("out_byte", want.out_byte, o_out_data.out_byte);
                if (o_out_data.byte_valid !== want.byte_valid)
                    report_field("byte_valid", 8'(want.byte_valid), 8'(o_out_data.byte_valid));
                if (o_out_data.message_end !== want.message_end)
                    report_field("message_end", 8'(want.message_end),
                                 8'(o_out_data.message_end));
                if (o_out_data.status !== want.status)
                    report_field("status", 8'(want.status), 8'(o_out_data.status));
            end
        end
    end

    // give up when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one request byte; random idle cycles before it, valid held until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, last_byte: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_request_byte(b, last);
        items_sent++;
        if (last) requests_sent++;
    endtask

    // sender holds off until every predicted result has come out
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], 1'b0);
    endtask

    task automatic send_header_end();
        send_byte(fvud_pkg::CH_CR, 1'b0);
        send_byte(fvud_pkg::CH_LF, 1'b0);
        send_byte(fvud_pkg::CH_CR, 1'b0);
        send_byte(fvud_pkg::CH_LF, 1'b0);
    endtask

    // shortest way into the value: empty header, key first in the body
    task automatic send_prefix();
        send_header_end();
        send_text("message=");
    endtask

    function automatic void add_str(input string s);
        for (int k = 0; k < s.len(); k++) req_bytes.push_back(s[k]);
    endfunction

    function automatic void add_printable(input int n);
        repeat (n) req_bytes.push_back(8'($urandom_range(33, 126)));
    endfunction

    function automatic void add_line_end();
        req_bytes.push_back(fvud_pkg::CH_CR);
        req_bytes.push_back(fvud_pkg::CH_LF);
    endfunction

    function automatic void add_hex_char();
        int d;
        d = $urandom_range(15);
        if (d < 10)
            req_bytes.push_back(8'("0" + d));
        else if ($urandom_range(1) == 0)
            req_bytes.push_back(8'("a" + d - 10));
        else
            req_bytes.push_back(8'("A" + d - 10));
    endfunction

    // one piece of value text: literal, plus, good or bad escape, raw byte
    function automatic void add_value_token();
        case ($urandom_range(9))
            0, 1, 2, 3: add_printable(1);
            4: req_bytes.push_back(fvud_pkg::CH_PLUS);
            5, 6: begin
                req_bytes.push_back(fvud_pkg::CH_PCT);
                add_hex_char();
                add_hex_char();
            end
            7: begin
                req_bytes.push_back(fvud_pkg::CH_PCT);
                add_printable(2);
            end
            8: req_bytes.push_back(8'($urandom_range(1, 255)));
            default: begin
                // escape with arbitrary bytes, a zero among them cuts it short
                req_bytes.push_back(fvud_pkg::CH_PCT);
                req_bytes.push_back(8'($urandom));
                req_bytes.push_back(8'($urandom));
            end
        endcase
    endfunction

    // how the value stops
    function automatic void add_value_end();
        case ($urandom_range(7))
            0: begin
                req_bytes.push_back(fvud_pkg::CH_AMP);
                add_printable(3);
            end
            1: begin
                req_bytes.push_back(fvud_pkg::CH_CR);
                add_line_end();
            end
            2: req_bytes.push_back(fvud_pkg::CH_LF);
            3: begin
                req_bytes.push_back(fvud_pkg::CH_NUL);
                add_printable(2);
            end
            4: req_bytes.push_back(fvud_pkg::CH_PCT);
            5: begin
                req_bytes.push_back(fvud_pkg::CH_PCT);
                add_hex_char();
            end
            6: add_str("&message=zz");
            default: ;
        endcase
    endfunction

    // mostly well-formed requests with random content, some broken, some noise
    task automatic random_request();
        int kind;
        int t;
        req_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            // pure noise, any byte value including zero
            repeat ($urandom_range(1, 24)) req_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                add_printable($urandom_range(1, 6));
                add_line_end();
            end
            if (kind < 22) begin
                // header end missing, broken or behind a zero byte, unless a line before completes it
                t = $urandom_range(2);
                if (t == 0) begin
                    add_line_end();
                end else if (t == 1) begin
                    add_line_end();
                    req_bytes.push_back(fvud_pkg::CH_CR);
                    add_printable(1);
                end else begin
                    req_bytes.push_back(fvud_pkg::CH_NUL);
                    add_line_end();
                    add_line_end();
                end
            end else begin
                add_line_end();
                add_line_end();
            end
            if ($urandom_range(3) == 0) add_str("name=a+b&");
            if (kind < 32) begin
                // key cut short, misspelled or behind a zero byte
                case ($urandom_range(3))
                    0: add_str("messag");
                    1: add_str("message");
                    2: add_str("mesage=");
                    default: begin
                        req_bytes.push_back(fvud_pkg::CH_NUL);
                        add_str("message=");
                    end
                endcase
            end else begin
                // partial key match first now and then
                if ($urandom_range(4) == 0) add_str("mess");
                add_str("message=");
            end
            repeat ($urandom_range(0, 14)) add_value_token();
            add_value_end();
        end
        foreach (req_bytes[k]) send_byte(req_bytes[k], k == req_bytes.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // header with a stray cr, key after a partial match, plus, escapes, raw extremes
    task automatic test_plain_and_escapes();
        send_text("H: x");
        send_byte(fvud_pkg::CH_CR, 1'b0);
        send_header_end();
        send_text("mmessage=a+%41%7e%FF%00");
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("&");
        send_byte("z", 1'b1);
    endtask

    // either digit outside 0-9 a-f A-F decodes to zero
    task automatic test_bad_hex();
        send_prefix();
        send_text("%G1%1z%zz");
        send_byte(fvud_pkg::CH_CR, 1'b0);
        send_byte("x", 1'b1);
    endtask

    // '%' with fewer than two bytes before a zero byte or the request end
    task automatic test_cut_escape();
        send_prefix();
        send_text("ab");
        send_byte(fvud_pkg::CH_PCT, 1'b1);
        send_prefix();
        send_text("%");
        send_byte("4", 1'b1);
        send_prefix();
        send_text("%");
        send_byte(fvud_pkg::CH_NUL, 1'b0);
        send_byte("y", 1'b1);
        send_prefix();
        send_text("%4");
        send_byte(fvud_pkg::CH_NUL, 1'b0);
        send_byte("q", 1'b1);
        // byte after '%' is itself '%', '&' or cr
        send_prefix();
        send_text("%");
        send_byte(fvud_pkg::CH_PCT, 1'b1);
        send_prefix();
        send_text("%");
        send_byte(fvud_pkg::CH_AMP, 1'b1);
        send_prefix();
        send_text("%");
        send_byte(fvud_pkg::CH_CR, 1'b1);
    endtask

    // failure reports: no header end, no key, zero byte before either
    task automatic test_failures();
        send_text("GET ");
        send_byte("/", 1'b1);
        send_byte(8'hFF, 1'b1);
        send_header_end();
        send_text("msg=");
        send_byte("1", 1'b1);
        send_text("ab");
        send_byte(fvud_pkg::CH_NUL, 1'b0);
        send_prefix();
        send_byte("x", 1'b1);
        send_header_end();
        send_text("mess");
        send_byte(fvud_pkg::CH_NUL, 1'b0);
        send_text("message=");
        send_byte("x", 1'b1);
        send_header_end();
        send_text("messag");
        send_byte("e", 1'b1);
    endtask

    // value with no bytes: one end marker only
    task automatic test_empty_value();
        send_prefix();
        send_byte(fvud_pkg::CH_AMP, 1'b0);
        send_byte("q", 1'b1);
        send_header_end();
        send_text("message");
        send_byte("=", 1'b1);
        send_prefix();
        send_byte(fvud_pkg::CH_LF, 1'b1);
    endtask

    // bytes after the value closes are ignored, last byte gives nothing
    task automatic test_after_close();
        send_prefix();
        send_text("x&yz%41message=b");
        send_byte("c", 1'b1);
    endtask

    // value longer than the cap: end marker on the last byte that fits
    task automatic test_value_cap();
        send_prefix();
        send_text("%41");
        for (int k = 0; k < CAP_BYTES + 8; k++) begin
            if ($urandom_range(7) == 0)
                send_byte(fvud_pkg::CH_PLUS, 1'b0);
            else
                send_byte(8'($urandom_range(97, 122)), 1'b0);
        end
        send_byte("!", 1'b1);
    endtask

    // random requests over the four idling phases, with occasional full drains
    task automatic test_random_requests();
        int share;
        int target;
        // the random part fills the run up to its total, split evenly over the phases
        share = (TOTAL_ITEMS - items_sent) / 4;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 63;
                end
                default: begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            target = items_sent + share;
            while (items_sent < target) begin
                random_request();
                if ($urandom_range(19) == 0) wait_results_drained();
            end
            wait_results_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        clear_decoder();
        // reset held from the start, released on a falling edge
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_and_escapes();
        test_bad_hex();
        test_cut_escape();
        test_failures();
        test_empty_value();
        test_after_close();
        wait_results_drained();

        send_idle_pct  = 16;
        recv_stall_pct = 16;
        test_value_cap();
        wait_results_drained();

        test_random_requests();

        // everything sent: wait for the tail, the watchdog bounds this
        wait_results_drained();
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            mismatches++;
        end

        $display("covered %0d requests, %0d bytes in, %0d results compared",
                 requests_sent, items_sent, results_checked);
        $display("values ended %0d (at cap %0d), no header end %0d, no key %0d, errors %0d",
                 values_closed + values_capped, values_capped, no_header_seen,
                 no_key_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
